[rtl/stsp_pkg.sv]
// ----------------------------------------------------------------------------
// stsp_pkg
// Shared constants, types and sign helpers for the sign-product segment tree.
// ----------------------------------------------------------------------------
package stsp_pkg;

   localparam int LEAVES = 1024;
   localparam int NODES  = 2 * LEAVES;
   localparam int NODE_W = $clog2(NODES);
   localparam int IDX_W  = 10;
   localparam int VAL_W  = 32;
   localparam int SIGN_W = 2;
   localparam int PTR_W  = ((NODE_W > IDX_W) ? NODE_W : IDX_W) + 1;

   localparam logic FUNC_UPDATE = 1'b0;
   localparam logic FUNC_QUERY  = 1'b1;

   localparam logic signed [SIGN_W-1:0] SIGN_ZERO = 2'sb00;
   localparam logic signed [SIGN_W-1:0] SIGN_POS  = 2'sb01;
   localparam logic signed [SIGN_W-1:0] SIGN_NEG  = 2'sb11;

   typedef logic signed [SIGN_W-1:0] sign_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic leaf_wr;
      logic upd_step;
      logic q_step;
      logic out_load;
   } stsp_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic req_query;
      logic req_upd_ok;
      logic upd_last;
      logic q_done;
      logic rsp_free;
   } stsp_sts_type;

   function automatic sign_type sign_of(input logic signed [VAL_W-1:0] v);
      sign_type s;
      if (v == '0) begin
         s = SIGN_ZERO;
      end else if (v[VAL_W-1]) begin
         s = SIGN_NEG;
      end else begin
         s = SIGN_POS;
      end
      return s;
   endfunction

   function automatic sign_type mul_sign(input sign_type a, input sign_type b);
      sign_type s;
      if ((a == SIGN_ZERO) || (b == SIGN_ZERO)) begin
         s = SIGN_ZERO;
      end else if (a == b) begin
         s = SIGN_POS;
      end else begin
         s = SIGN_NEG;
      end
      return s;
   endfunction

endpackage

[rtl/stsp_req_if.sv]
// ----------------------------------------------------------------------------
// stsp_req_if
// Request channel: update or range query transaction.
// ----------------------------------------------------------------------------
interface stsp_req_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    func;
   logic [stsp_pkg::IDX_W-1:0]              first_index;
   logic [stsp_pkg::IDX_W-1:0]              last_index;
   logic signed [stsp_pkg::VAL_W-1:0]       new_value;

   modport source (output valid, output func, output first_index, output last_index,
                   output new_value, input ready);
   modport sink   (input valid, input func, input first_index, input last_index,
                   input new_value, output ready);
endinterface

[rtl/stsp_rsp_if.sv]
// ----------------------------------------------------------------------------
// stsp_rsp_if
// Response channel: sign of a range product.
// ----------------------------------------------------------------------------
interface stsp_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [stsp_pkg::SIGN_W-1:0]      sign_product;

   modport source (output valid, output sign_product, input ready);
   modport sink   (input valid, input sign_product, output ready);
endinterface

[rtl/segment_tree_sign_product.sv]
// ----------------------------------------------------------------------------
// segment_tree_sign_product
// Bottom-up segment tree of signs with point update and range sign product.
// ----------------------------------------------------------------------------
//  channel   dir   transaction
//  req_chan  in    func, first_index, last_index, new_value
//  rsp_chan  out   sign_product (one per query, none per update)
//
//  Update: accept, leaf write, then one parent write per tree level.
//  Query: accept, up to log2(LEAVES)+1 levels on a 2-read RAM, read drain, done
//  check, result load; an empty range goes straight to the done check.
//  Reset starts a clearing pass over all 2*LEAVES nodes (2048) with req_chan.ready low.
//  The result register frees the core; a query waits only if it is still full.
// ----------------------------------------------------------------------------
module segment_tree_sign_product (
   input  logic        clock,
   input  logic        reset,
   stsp_req_if.sink    req_chan,
   stsp_rsp_if.source  rsp_chan
);

   stsp_pkg::stsp_cmd_type cmd;
   stsp_pkg::stsp_sts_type sts;

   stsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   stsp_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .func         (req_chan.func),
      .first_index  (req_chan.first_index),
      .last_index   (req_chan.last_index),
      .new_value    (req_chan.new_value),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .sign_product (rsp_chan.sign_product)
   );

endmodule

[rtl/stsp_ram.sv]
// ----------------------------------------------------------------------------
// stsp_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module stsp_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 2048
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr_a,
   output logic [WIDTH-1:0]          rd_data_a,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr_b,
   output logic [WIDTH-1:0]          rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[rtl/stsp_ctrl.sv]
// ----------------------------------------------------------------------------
// stsp_ctrl
// Sequencer: clearing pass, leaf update walk, range query walk, result load.
// ----------------------------------------------------------------------------
module stsp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  stsp_pkg::stsp_sts_type sts,
   output stsp_pkg::stsp_cmd_type cmd
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_LEAF   = 3'd2;
   localparam logic [2:0] ST_UPD    = 3'd3;
   localparam logic [2:0] ST_QUERY  = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (sts.req_query) begin
                  state_in = ST_QUERY;
               end else if (sts.req_upd_ok) begin
                  state_in = ST_LEAF;
               end
            end
         end
         ST_LEAF: begin
            cmd.leaf_wr = 1'b1;
            state_in    = ST_UPD;
         end
         ST_UPD: begin
            cmd.upd_step = 1'b1;
            if (sts.upd_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_QUERY: begin
            if (sts.q_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.q_step = 1'b1;
            end
         end
         ST_FINISH: begin
            if (sts.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/stsp_dp.sv]
// ----------------------------------------------------------------------------
// stsp_dp
// Datapath: node memory, walk pointers, running sign products, result register.
// ----------------------------------------------------------------------------
module stsp_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  stsp_pkg::stsp_cmd_type               cmd,
   output stsp_pkg::stsp_sts_type               sts,
   input  logic                                 func,
   input  logic [stsp_pkg::IDX_W-1:0]           first_index,
   input  logic [stsp_pkg::IDX_W-1:0]           last_index,
   input  logic signed [stsp_pkg::VAL_W-1:0]    new_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [stsp_pkg::SIGN_W-1:0]   sign_product
);

   localparam int NW = stsp_pkg::NODE_W;
   localparam int PW = stsp_pkg::PTR_W;
   localparam int IW = stsp_pkg::IDX_W;

   logic [NW-1:0]          clr_cnt_ff, clr_cnt_in;
   logic [NW-1:0]          node_ff, node_in;
   stsp_pkg::sign_type     val_ff, val_in;
   logic [PW-1:0]          lo_ff, lo_in;
   logic [PW-1:0]          hi_ff, hi_in;
   logic                   rda_pend_ff, rda_pend_in;
   logic                   rdb_pend_ff, rdb_pend_in;
   stsp_pkg::sign_type     left_ff, left_in;
   stsp_pkg::sign_type     right_ff, right_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   stsp_pkg::sign_type     rsp_data_ff, rsp_data_in;

   logic [NW-1:0]          parent;
   stsp_pkg::sign_type     prod;
   logic                   q_live;
   logic                   lo_odd;
   logic                   hi_odd;
   logic [PW-1:0]          lo_adj;
   logic [PW-1:0]          hi_adj;
   logic [IW-1:0]          last_clamp;

   logic                   wr_en;
   logic [NW-1:0]          wr_addr;
   logic [1:0]             wr_data;
   logic [NW-1:0]          rd_addr_a;
   logic [NW-1:0]          rd_addr_b;
   logic [1:0]             rd_data_a;
   logic [1:0]             rd_data_b;

   stsp_ram #(
      .WIDTH (stsp_pkg::SIGN_W),
      .DEPTH (stsp_pkg::NODES)
   ) u_nodes (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   assign parent = node_ff >> 1;
   assign prod   = stsp_pkg::mul_sign(val_ff, stsp_pkg::sign_type'(rd_data_a));
   assign q_live = (lo_ff < hi_ff);
   assign lo_odd = q_live && lo_ff[0];
   assign hi_odd = q_live && hi_ff[0];
   assign lo_adj = lo_ff + PW'(lo_odd);
   assign hi_adj = hi_ff - PW'(hi_odd);
   assign last_clamp = (32'(last_index) >= stsp_pkg::LEAVES) ?
                       IW'(stsp_pkg::LEAVES - 1) : last_index;

   assign rd_addr_a = cmd.q_step  ? lo_ff[NW-1:0] :
                      cmd.leaf_wr ? (node_ff ^ NW'(1)) : (parent ^ NW'(1));
   assign rd_addr_b = hi_adj[NW-1:0];

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_cnt_ff;
      wr_data = stsp_pkg::SIGN_ZERO;
      if (cmd.clear) begin
         wr_en = 1'b1;
      end else if (cmd.leaf_wr) begin
         wr_en   = 1'b1;
         wr_addr = node_ff;
         wr_data = val_ff;
      end else if (cmd.upd_step) begin
         wr_en   = 1'b1;
         wr_addr = parent;
         wr_data = prod;
      end
   end

   always_comb begin
      clr_cnt_in   = clr_cnt_ff;
      node_in      = node_ff;
      val_in       = val_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rda_pend_in  = rda_pend_ff;
      rdb_pend_in  = rdb_pend_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (cmd.clear) begin
         clr_cnt_in = clr_cnt_ff + NW'(1);
      end
      if (cmd.load) begin
         node_in     = NW'(stsp_pkg::LEAVES) + NW'(first_index);
         val_in      = stsp_pkg::sign_of(new_value);
         lo_in       = PW'(first_index) + PW'(stsp_pkg::LEAVES);
         hi_in       = PW'(last_clamp) + PW'(stsp_pkg::LEAVES) + PW'(1);
         rda_pend_in = 1'b0;
         rdb_pend_in = 1'b0;
         left_in     = stsp_pkg::SIGN_POS;
         right_in    = stsp_pkg::SIGN_POS;
      end
      if (cmd.upd_step) begin
         node_in = parent;
         val_in  = prod;
      end
      if (cmd.q_step) begin
         if (rda_pend_ff) begin
            left_in = stsp_pkg::mul_sign(left_ff, stsp_pkg::sign_type'(rd_data_a));
         end
         if (rdb_pend_ff) begin
            right_in = stsp_pkg::mul_sign(right_ff, stsp_pkg::sign_type'(rd_data_b));
         end
         rda_pend_in = lo_odd;
         rdb_pend_in = hi_odd;
         if (q_live) begin
            lo_in = lo_adj >> 1;
            hi_in = hi_adj >> 1;
         end
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = stsp_pkg::mul_sign(left_ff, right_ff);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         rda_pend_ff  <= 1'b0;
         rdb_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_cnt_ff   <= clr_cnt_in;
         rda_pend_ff  <= rda_pend_in;
         rdb_pend_ff  <= rdb_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      node_ff     <= node_in;
      val_ff      <= val_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign sts.clr_last   = (clr_cnt_ff == NW'(stsp_pkg::NODES - 1));
   assign sts.req_query  = (func == stsp_pkg::FUNC_QUERY);
   assign sts.req_upd_ok = (32'(first_index) < stsp_pkg::LEAVES);
   assign sts.upd_last   = (parent == NW'(1));
   assign sts.q_done     = !q_live && !rda_pend_ff && !rdb_pend_ff;
   assign sts.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign sign_product = rsp_data_ff;

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench for segment_tree_sign_product. A driver process sends update and
// range query transactions in random bursts. A monitor process stalls the
// result channel on its own pattern and checks each sign against a
// behavioral copy of the tree kept in the testbench.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [stsp_pkg::IDX_W-1:0]        idx_type;
   typedef logic signed [stsp_pkg::VAL_W-1:0] val_type;

   typedef struct {
      logic                      func;
      idx_type                   first_index;
      idx_type                   last_index;
      val_type                   new_value;
      bit                        wait_idle;
   } tree_op_type;

   typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_type;

   logic clock = 1'b0;
   logic reset;

   stsp_req_if req_chan ();
   stsp_rsp_if rsp_chan ();

   segment_tree_sign_product u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #10 clock = ~clock;

   // shadow tree of signs, leaf p at node LEAVES + p
   stsp_pkg::sign_type   node_sign [stsp_pkg::NODES];
   tree_op_type          pending_ops [$];
   stsp_pkg::sign_type   sign_expect [$];
   tree_op_type          next_op;
   int                   accepted_count = 0;
   int                   total_ops      = 0;
   int                   checked_count  = 0;
   int                   error_count    = 0;
   int                   gap_left       = 0;
   int                   burst_left     = 0;
   int                   hold_left      = 0;
   int                   mode_left      = 0;
   int                   rx_cycle       = 0;
   rx_mode_type          rx_mode        = RX_FREE;
   stsp_pkg::sign_type   want;

   function automatic stsp_pkg::sign_type value_sign(input val_type v);
      if (v == 0) begin
         return stsp_pkg::sign_type'(0);
      end
      return (v < 0) ? stsp_pkg::sign_type'(-1) : stsp_pkg::sign_type'(1);
   endfunction

   function automatic stsp_pkg::sign_type sign_times(input stsp_pkg::sign_type a,
                                                     input stsp_pkg::sign_type b);
      int p;
      p = int'(a) * int'(b);
      return stsp_pkg::sign_type'(p);
   endfunction

   function automatic void store_leaf(input int pos, input val_type v);
      int n;
      n = pos + stsp_pkg::LEAVES;
      node_sign[n] = value_sign(v);
      for (n = n >> 1; n > 0; n = n >> 1) begin
         node_sign[n] = sign_times(node_sign[2*n], node_sign[2*n+1]);
      end
   endfunction

   function automatic stsp_pkg::sign_type range_product(input int first, input int last);
      stsp_pkg::sign_type lsum;
      stsp_pkg::sign_type rsum;
      int       lo;
      int       hi;
      lsum = stsp_pkg::sign_type'(1);
      rsum = stsp_pkg::sign_type'(1);
      if (last >= stsp_pkg::LEAVES) begin
         last = stsp_pkg::LEAVES - 1;
      end
      if (first > last) begin
         return stsp_pkg::sign_type'(1);
      end
      lo = first + stsp_pkg::LEAVES;
      hi = last + 1 + stsp_pkg::LEAVES;
      while (lo < hi) begin
         if (lo[0]) begin
            lsum = sign_times(lsum, node_sign[lo]);
            lo++;
         end
         if (hi[0]) begin
            hi--;
            rsum = sign_times(rsum, node_sign[hi]);
         end
         lo = lo >> 1;
         hi = hi >> 1;
      end
      return sign_times(lsum, rsum);
   endfunction

   function automatic void add_update(input int pos, input val_type v,
                                      input bit hold = 1'b0);
      tree_op_type op;
      op.func        = stsp_pkg::FUNC_UPDATE;
      op.first_index = idx_type'(pos);
      op.last_index  = idx_type'($urandom);
      op.new_value   = v;
      op.wait_idle   = hold;
      pending_ops.push_back(op);
   endfunction

   function automatic void add_query(input int first, input int last, input bit hold = 1'b0);
      tree_op_type op;
      op.func        = stsp_pkg::FUNC_QUERY;
      op.first_index = idx_type'(first);
      op.last_index  = idx_type'(last);
      op.new_value   = val_type'($urandom);
      op.wait_idle   = hold;
      pending_ops.push_back(op);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            if (req_chan.func == stsp_pkg::FUNC_UPDATE) begin
               store_leaf(int'(req_chan.first_index), req_chan.new_value);
            end else begin
               sign_expect.push_back(range_product(int'(req_chan.first_index),
                                                   int'(req_chan.last_index)));
            end
            accepted_count++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (pending_ops.size() != 0 &&
                         !(pending_ops[0].wait_idle && sign_expect.size() != 0)) begin
               next_op = pending_ops.pop_front();
               req_chan.valid       <= 1'b1;
               req_chan.func        <= next_op.func;
               req_chan.first_index <= next_op.first_index;
               req_chan.last_index  <= next_op.last_index;
               req_chan.new_value   <= next_op.new_value;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                                           : $urandom_range(0, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rx_cycle++;
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (sign_expect.size() == 0) begin
               $display("%0t: unexpected transaction, actual %0d", $time,
                        rsp_chan.sign_product);
               error_count++;
            end else begin
               want = sign_expect.pop_front();
               if (rsp_chan.sign_product !== want) begin
                  $display("%0t: sign_product mismatch, expected %0d, actual %0d",
                           $time, want, rsp_chan.sign_product);
                  error_count++;
               end
            end
            checked_count++;
            if (checked_count == 50 || checked_count == 600) begin
               hold_left = 400;
            end
         end
         if (mode_left > 0) begin
            mode_left--;
         end else begin
            mode_left = $urandom_range(20, 300);
            rx_mode   = rx_mode_type'($urandom_range(0, 3));
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_FREE: begin
                  rsp_chan.ready <= 1'b1;
               end
               RX_COIN: begin
                  rsp_chan.ready <= 1'($urandom_range(0, 1));
               end
               RX_SPARSE: begin
                  rsp_chan.ready <= ($urandom_range(0, 4) == 0);
               end
               default: begin
                  rsp_chan.ready <= (rx_cycle % 16) < 10;
               end
            endcase
         end
      end
   end

   initial begin
      int base;
      int a;
      int b;
      int r;
      val_type v;

      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.func        = stsp_pkg::FUNC_UPDATE;
      req_chan.first_index = '0;
      req_chan.last_index  = '0;
      req_chan.new_value   = '0;
      rsp_chan.ready       = 1'b0;
      foreach (node_sign[i]) begin
         node_sign[i] = stsp_pkg::sign_type'(0);
      end

      // directed
      add_query(0, stsp_pkg::LEAVES - 1);
      add_query(5, 3);
      add_update(0, 32'sh8000_0000);
      add_update(stsp_pkg::LEAVES - 1, 32'sh7FFF_FFFF);
      add_update(512, -1);
      add_query(0, 0);
      add_query(stsp_pkg::LEAVES - 1, stsp_pkg::LEAVES - 1);
      add_query(stsp_pkg::LEAVES - 1, 0);
      add_query(0, stsp_pkg::LEAVES - 1, 1'b1);
      add_update(1, 1);
      add_update(2, -7);
      add_update(3, 32'sh0000_0100);
      add_query(0, 3);
      add_query(1, 3);
      add_query(1, 2);
      add_update(0, 0);
      add_query(0, 0);
      add_query(0, 3);
      add_query(1023, 1022);
      add_query(512, 512);
      add_update(512, 32'sh7FFF_FFFF);
      add_query(511, 513);
      add_query(512, 512, 1'b1);

      // random, mostly inside a moving window so products are nonzero
      base = stsp_pkg::LEAVES - 64;
      for (int k = 0; k < 1700; k++) begin
         if (k % 150 == 149) begin
            base = $urandom_range(0, 15) * 64;
         end
         r = $urandom_range(0, 99);
         if (r < 45) begin
            a = ($urandom_range(0, 9) < 8) ? base + $urandom_range(0, 63)
                                           : $urandom_range(0, stsp_pkg::LEAVES - 1);
            v = val_type'($urandom);
            if ($urandom_range(0, 7) == 0) begin
               v = '0;
            end
            add_update(a, v, $urandom_range(0, 99) == 0);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
               a = $urandom_range(1, stsp_pkg::LEAVES - 1);
               b = $urandom_range(0, a - 1);
            end else if (r < 15) begin
               a = $urandom_range(0, stsp_pkg::LEAVES - 1);
               b = $urandom_range(a, stsp_pkg::LEAVES - 1);
            end else if (r < 25) begin
               a = base + $urandom_range(0, 63);
               b = a;
            end else begin
               a = base + $urandom_range(0, 63);
               b = $urandom_range(a, base + 63);
            end
            add_query(a, b, $urandom_range(0, 99) == 0);
         end
      end
      total_ops = pending_ops.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_ops) @(posedge clock);
      while (sign_expect.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("[segment_tree_sign_product] OK");
      end else begin
         $display("[segment_tree_sign_product] ERROR");
      end
      $finish;
   end

   initial begin
      #12_000_000;
      $display("[segment_tree_sign_product] ERROR");
      $finish;
   end

endmodule
